>>> hdl/lsb_stego_payload_extractor_assert.svh
// ----------------------------------------------------------------------------
// LSB stego extractor assertion macros
// Short forms for the concurrent checks, clocked on aclk, reset by aresetn.
// ----------------------------------------------------------------------------
`ifndef LSB_STEGO_PAYLOAD_EXTRACTOR_ASSERT_SVH
`define LSB_STEGO_PAYLOAD_EXTRACTOR_ASSERT_SVH

// Same-cycle implication.
`define LSPE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LSPE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lspe_pkg.sv
// ----------------------------------------------------------------------------
// LSB stego extractor package
// Shared types, codes and defaults.
// ----------------------------------------------------------------------------
package lspe_pkg;

    localparam int LSPE_MAGIC_BYTES_MAX = 8;
    localparam logic [7:0] LSPE_HEADER_BYTES_RST = 8'd54;
    localparam int LSPE_LEN_BYTES = 4;

    // Configuration register indexes
    localparam logic [1:0] CFG_IDX_HEADER_BYTES = 2'd0;
    localparam logic [1:0] CFG_IDX_MAGIC_LEN    = 2'd1;
    localparam logic [1:0] CFG_IDX_MAGIC_VALUE  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_EXT      = 2'd0;
    localparam logic [1:0] KIND_PAY      = 2'd1;
    localparam logic [1:0] KIND_MISMATCH = 2'd2;
    localparam logic [1:0] KIND_EMPTY    = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_MAGIC  = 3'd1,
        PH_EXTLEN = 3'd2,
        PH_EXT    = 3'd3,
        PH_PAYLEN = 3'd4,
        PH_PAY    = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0]  header_bytes;
        logic [3:0]  magic_len;
        logic [63:0] magic_value;
    } cfg_t;

    typedef struct packed {
        logic vld;
        logic lsb;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       last;
    } result_t;

endpackage

>>> hdl/lspe_in_stage.sv
// ----------------------------------------------------------------------------
// LSB stego extractor input stage
// Registers the carrier bit of each accepted image word.
// ----------------------------------------------------------------------------
module lspe_in_stage
    import lspe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_pixel_byte,
    input  logic       take,
    output in_word_t   word
);

    logic vld_reg, vld_next;
    logic lsb_reg;

    // Refill whenever empty or drained this cycle
    assign s_ready  = !vld_reg || take;
    assign vld_next = s_ready ? s_valid : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            lsb_reg <= s_pixel_byte[0];
        end
    end

    assign word.vld = vld_reg;
    assign word.lsb = lsb_reg;

endmodule

>>> hdl/lspe_decoder.sv
// ----------------------------------------------------------------------------
// LSB stego extractor decoder
// Header skip, bit gathering and stream framing for one word per cycle while the output has room.
// ----------------------------------------------------------------------------
module lspe_decoder
    import lspe_pkg::*;
#(
    parameter int MAGIC_BYTES_MAX = LSPE_MAGIC_BYTES_MAX
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  in_word_t word,
    input  logic     out_free,
    output logic     take,
    output logic     res_vld,
    output result_t  res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  header_count_reg, header_count_next;
    logic [2:0]  bit_count_reg, bit_count_next;
    logic [6:0]  bit_shift_reg, bit_shift_next;
    logic [3:0]  field_count_reg, field_count_next;
    logic [31:0] length_accum_reg, length_accum_next;
    logic [31:0] remaining_reg, remaining_next;

    logic [3:0]  magic_limit;
    phase_t      ph;
    logic        active;
    logic [7:0]  byte_w;
    logic [7:0]  expect_byte;
    logic [3:0]  fc_inc;
    logic [31:0] la_new;
    logic [31:0] rem_dec;

    assign magic_limit = (cfg.magic_len > 4'(MAGIC_BYTES_MAX)) ? 4'(MAGIC_BYTES_MAX)
                                                              : cfg.magic_len;

    always_comb begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        bit_count_next    = bit_count_reg;
        bit_shift_next    = bit_shift_reg;
        field_count_next  = field_count_reg;
        length_accum_next = length_accum_reg;
        remaining_next    = remaining_reg;
        res_vld           = 1'b0;
        res               = '0;
        ph                = phase_reg;
        active            = 1'b1;
        byte_w            = {bit_shift_reg, word.lsb};
        expect_byte       = '0;
        fc_inc            = '0;
        la_new            = '0;
        rem_dec           = remaining_reg - 32'd1;

        // Header end falls through into the first hidden bit
        if (phase_reg == PH_HEADER) begin
            if (header_count_reg < cfg.header_bytes) begin
                header_count_next = header_count_reg + 8'd1;
                active            = 1'b0;
            end else begin
                ph                = (magic_limit != 4'd0) ? PH_MAGIC : PH_EXTLEN;
                phase_next        = ph;
                field_count_next  = '0;
                length_accum_next = '0;
                byte_w            = {7'd0, word.lsb};
            end
        end

        fc_inc      = (ph == PH_HEADER) ? field_count_reg + 4'd1 : field_count_next + 4'd1;
        expect_byte = cfg.magic_value[8*field_count_next[2:0] +: 8];
        la_new      = length_accum_next;
        case (field_count_next[1:0])
            2'd0:    la_new[7:0]   = length_accum_next[7:0]   | byte_w;
            2'd1:    la_new[15:8]  = length_accum_next[15:8]  | byte_w;
            2'd2:    la_new[23:16] = length_accum_next[23:16] | byte_w;
            default: la_new[31:24] = length_accum_next[31:24] | byte_w;
        endcase

        if (active && ph >= PH_MAGIC && ph <= PH_PAY) begin
            if (((phase_reg == PH_HEADER) ? 3'd0 : bit_count_reg) != 3'd7) begin
                bit_count_next = ((phase_reg == PH_HEADER) ? 3'd0 : bit_count_reg) + 3'd1;
                bit_shift_next = byte_w[6:0];
            end else begin
                bit_count_next = '0;
                bit_shift_next = '0;
                case (ph)
                    PH_MAGIC: begin
                        if (byte_w != expect_byte) begin
                            phase_next = PH_DONE;
                            res_vld    = 1'b1;
                            res        = '{out_byte: 8'd0, out_kind: KIND_MISMATCH,
                                           last: 1'b1};
                        end else if (fc_inc >= magic_limit) begin
                            phase_next        = PH_EXTLEN;
                            field_count_next  = '0;
                            length_accum_next = '0;
                        end else begin
                            field_count_next = fc_inc;
                        end
                    end
                    PH_EXTLEN, PH_PAYLEN: begin
                        if (fc_inc >= 4'(LSPE_LEN_BYTES)) begin
                            remaining_next    = la_new;
                            length_accum_next = '0;
                            field_count_next  = '0;
                            if (ph == PH_EXTLEN) begin
                                phase_next = (la_new == 32'd0) ? PH_PAYLEN : PH_EXT;
                            end else if (la_new == 32'd0) begin
                                phase_next = PH_DONE;
                                res_vld    = 1'b1;
                                res        = '{out_byte: 8'd0, out_kind: KIND_EMPTY,
                                               last: 1'b1};
                            end else begin
                                phase_next = PH_PAY;
                            end
                        end else begin
                            length_accum_next = la_new;
                            field_count_next  = fc_inc;
                        end
                    end
                    PH_EXT: begin
                        remaining_next = rem_dec;
                        if (rem_dec == 32'd0) begin
                            phase_next = PH_PAYLEN;
                        end
                        res_vld = 1'b1;
                        res     = '{out_byte: byte_w, out_kind: KIND_EXT, last: 1'b0};
                    end
                    PH_PAY: begin
                        remaining_next = rem_dec;
                        if (rem_dec == 32'd0) begin
                            phase_next = PH_DONE;
                        end
                        res_vld = 1'b1;
                        res     = '{out_byte: byte_w, out_kind: KIND_PAY,
                                    last: (rem_dec == 32'd0)};
                    end
                    default: begin
                        res_vld = 1'b0;
                    end
                endcase
            end
        end
    end

    // Hold the word only when it yields a result and the output is busy
    assign take = word.vld && (!res_vld || out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= '0;
            bit_count_reg    <= '0;
            bit_shift_reg    <= '0;
            field_count_reg  <= '0;
            length_accum_reg <= '0;
            remaining_reg    <= '0;
        end else if (take) begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            bit_count_reg    <= bit_count_next;
            bit_shift_reg    <= bit_shift_next;
            field_count_reg  <= field_count_next;
            length_accum_reg <= length_accum_next;
            remaining_reg    <= remaining_next;
        end
    end

endmodule

>>> hdl/lspe_out_stage.sv
// ----------------------------------------------------------------------------
// LSB stego extractor output stage
// Result register toward the receiver.
// ----------------------------------------------------------------------------
module lspe_out_stage
    import lspe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  result_t    res,
    output logic       out_free,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_out_kind,
    output logic       m_last
);

    logic    vld_reg, vld_next;
    result_t res_reg;

    assign out_free = !vld_reg || m_ready;
    assign vld_next = load || (vld_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid    = vld_reg;
    assign m_out_byte = res_reg.out_byte;
    assign m_out_kind = res_reg.out_kind;
    assign m_last     = res_reg.last;

endmodule

>>> hdl/lsb_stego_payload_extractor.sv
// ----------------------------------------------------------------------------
// LSB steganography payload extractor
// Recovers extension and payload bytes hidden in image byte LSBs.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one raw image byte per word; only bit 0 is used after the
//   header. m_ channel: one result word per recovered extension or payload
//   byte, or one status word (magic mismatch, empty payload) with m_last set.
//   cfg_ channel: register writes (0 header length, 1 magic length,
//   2 magic value); cfg_ready is always high; write only while idle.
// Timing:
//   An input word is registered in the input stage, decoded combinationally,
//   and its result is loaded into the output register, which drives m_valid.
//   One image byte is taken every cycle unless a result waits on a full
//   output register, so a hidden byte completes every eight input words.
// Reset:
//   aresetn clears all control state and restores the register defaults
//   (54 header bytes, magic check off); decoding restarts at the header.
// Stall:
//   While m_ready is low the result register holds; input words that yield
//   no result keep flowing, and the first one that would yield a result
//   waits in the input register, which drops s_ready.
// ----------------------------------------------------------------------------
module lsb_stego_payload_extractor
    import lspe_pkg::*;
#(
    parameter int MAGIC_BYTES_MAX = LSPE_MAGIC_BYTES_MAX
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_pixel_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_out_kind,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    cfg_t     cfg_reg;
    in_word_t word;
    logic     take;
    logic     res_vld;
    result_t  res;
    logic     out_free;

    // Configuration writes land at once; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_bytes <= LSPE_HEADER_BYTES_RST;
            cfg_reg.magic_len    <= '0;
            cfg_reg.magic_value  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_HEADER_BYTES: cfg_reg.header_bytes <= cfg_data[7:0];
                CFG_IDX_MAGIC_LEN:    cfg_reg.magic_len    <= cfg_data[3:0];
                CFG_IDX_MAGIC_VALUE:  cfg_reg.magic_value  <= cfg_data;
                default:              cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Hold the carrier bit of each accepted word
    lspe_in_stage u_in (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_byte (s_pixel_byte),
        .take         (take),
        .word         (word)
    );

    // Skip the header, then advance the framing state by one bit per word
    lspe_decoder #(
        .MAGIC_BYTES_MAX (MAGIC_BYTES_MAX)
    ) u_dec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .word     (word),
        .out_free (out_free),
        .take     (take),
        .res_vld  (res_vld),
        .res      (res)
    );

    // Register results toward the receiver
    lspe_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (take && res_vld),
        .res        (res),
        .out_free   (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_kind (m_out_kind),
        .m_last     (m_last)
    );

endmodule

>>> hdl/lspe_checker.sv
// ----------------------------------------------------------------------------
// LSB stego extractor port checker
// Watches the result channel of the top level over time.
// ----------------------------------------------------------------------------
`include "lsb_stego_payload_extractor_assert.svh"

module lspe_checker
    import lspe_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic [1:0] m_out_kind,
    input logic       m_last
);

    logic done_reg, done_next;

    // Mark the stream finished once the last word leaves
    assign done_next = done_reg || (m_valid && m_ready && m_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
        end
    end

    `LSPE_ASSERT_NXT(a_stall_hold, m_valid && !m_ready,
        m_valid && $stable(m_out_byte) && $stable(m_out_kind) && $stable(m_last),
        "result changed while stalled")

    `LSPE_ASSERT_IMP(a_status_word,
        m_valid && (m_out_kind == KIND_MISMATCH || m_out_kind == KIND_EMPTY),
        m_last && m_out_byte == 8'd0,
        "status word without last or with data")

    `LSPE_ASSERT_IMP(a_ext_not_last, m_valid && m_out_kind == KIND_EXT, !m_last,
        "extension byte marked last")

    `LSPE_ASSERT_IMP(a_quiet_after_last, done_reg, !m_valid,
        "result after end of stream")

endmodule

bind lsb_stego_payload_extractor lspe_checker u_lspe_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_out_kind (m_out_kind),
    .m_last     (m_last)
);
